// ===== design/wfs_pkg.sv =====
`timescale 1ns / 1ps

package wfs_pkg;

  // field widths
  localparam int unsigned PtrW   = 12;
  localparam int unsigned RowW   = 11;
  localparam int unsigned SlotW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PixW   = 3 * ByteW;
  localparam int unsigned CfgIdxW = 3;

  // default store size in leds
  localparam int unsigned DefMaxLeds = 1024;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FRAME_BYTES = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BIT_PERIOD  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LATCH_PER   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LATCH_HIGH  = 3'd5;

  // configuration reset values
  localparam logic [PtrW-1:0]  RST_FRAME_BYTES = 12'd2400;
  localparam logic [SlotW-1:0] RST_BIT_PERIOD  = 16'd150;
  localparam logic [SlotW-1:0] RST_ONE_HIGH    = 16'd96;
  localparam logic [SlotW-1:0] RST_ZERO_HIGH   = 16'd48;
  localparam logic [SlotW-1:0] RST_LATCH_PER   = 16'd6100;
  localparam logic [SlotW-1:0] RST_LATCH_HIGH  = 16'd2;

  // input kinds carried on tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // byte position inside one pixel row
  localparam logic [1:0] SUB_GREEN = 2'd0;
  localparam logic [1:0] SUB_RED   = 2'd1;
  localparam logic [1:0] SUB_BLUE  = 2'd2;

  typedef struct packed {
    logic [PtrW-1:0]  frame_bytes;
    logic [SlotW-1:0] bit_period;
    logic [SlotW-1:0] one_high;
    logic [SlotW-1:0] zero_high;
    logic [SlotW-1:0] latch_period;
    logic [SlotW-1:0] latch_high;
  } cfg_t;

  // a zero period is reported as a period of one
  function automatic logic [SlotW-1:0] nonzero_period(input logic [SlotW-1:0] p);
    nonzero_period = (p == '0) ? SlotW'(1) : p;
  endfunction

endpackage

// ===== design/wfs_ram.sv =====
`timescale 1ns / 1ps

module wfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wfs_cfg_regs.sv =====
`timescale 1ns / 1ps

module wfs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [wfs_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [wfs_pkg::SlotW-1:0]    data_i,
  output wfs_pkg::cfg_t                cfg_o
);
  import wfs_pkg::*;

  cfg_t cfg_q;

  // register file, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_bytes  <= RST_FRAME_BYTES;
      cfg_q.bit_period   <= RST_BIT_PERIOD;
      cfg_q.one_high     <= RST_ONE_HIGH;
      cfg_q.zero_high    <= RST_ZERO_HIGH;
      cfg_q.latch_period <= RST_LATCH_PER;
      cfg_q.latch_high   <= RST_LATCH_HIGH;
    end else if (we_i) begin
      case (idx_i)
        REG_FRAME_BYTES: cfg_q.frame_bytes  <= data_i[PtrW-1:0];
        REG_BIT_PERIOD:  cfg_q.bit_period   <= data_i;
        REG_ONE_HIGH:    cfg_q.one_high     <= data_i;
        REG_ZERO_HIGH:   cfg_q.zero_high    <= data_i;
        REG_LATCH_PER:   cfg_q.latch_period <= data_i;
        REG_LATCH_HIGH:  cfg_q.latch_high   <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/wfs_core.sv =====
`timescale 1ns / 1ps

module wfs_core #(
  parameter int unsigned MaxLeds = wfs_pkg::DefMaxLeds
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wfs_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_op_i,
  input  logic [wfs_pkg::PtrW-1:0]   in_led_index_i,
  input  logic [wfs_pkg::ByteW-1:0]  in_red_i,
  input  logic [wfs_pkg::ByteW-1:0]  in_green_i,
  input  logic [wfs_pkg::ByteW-1:0]  in_blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wfs_pkg::SlotW-1:0]  out_period_o,
  output logic [wfs_pkg::SlotW-1:0]  out_high_o,
  output logic                       out_latch_o
);
  import wfs_pkg::*;

  localparam int unsigned AddrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam logic [AddrW-1:0] LastRow = AddrW'(MaxLeds - 1);
  localparam logic [PtrW:0] LedLimit = (PtrW + 1)'(MaxLeds);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] clr_cnt_q;

  // serializer state
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [1:0]       sub_q, sub_d;
  logic [2:0]       bit_cnt_q, bit_cnt_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic             latch_due_q, latch_due_d;
  logic             pend_q, pend_d;
  logic [1:0]       rd_sub_q;
  logic             rd_oor_q;

  // result register
  logic             out_valid_q;
  logic [SlotW-1:0] out_period_q, out_period_d;
  logic [SlotW-1:0] out_high_q, out_high_d;
  logic             out_latch_q, out_latch_d;

  logic             accept, tick, pix_we, rd_en;
  logic [PtrW:0]    ptr_inc;
  logic             wrap;
  logic [PtrW-1:0]  row_ext;
  logic [PixW-1:0]  rdata;
  logic [ByteW-1:0] ram_byte, cur_byte;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [PixW-1:0]  ram_wdata;

  // input is held off during the clearing pass and while a result is stuck
  assign in_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign tick       = accept && (in_op_i == OP_TICK);
  assign pix_we     = accept && (in_op_i == OP_PIXEL)
                      && ({1'b0, in_led_index_i} < LedLimit);

  // clearing pass state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AddrW'(1);
          if (clr_cnt_q == LastRow) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN:  state_q <= ST_RUN;
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  // store write port: clearing rows or pixel writes
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = pix_we;
      ram_waddr = in_led_index_i[AddrW-1:0];
      ram_wdata = {in_blue_i, in_red_i, in_green_i};
    end
  end

  // pick the prefetched byte out of its pixel row
  always_comb begin
    case (rd_sub_q)
      SUB_GREEN: ram_byte = rdata[ByteW-1:0];
      SUB_RED:   ram_byte = rdata[2*ByteW-1:ByteW];
      SUB_BLUE:  ram_byte = rdata[3*ByteW-1:2*ByteW];
      default:   ram_byte = '0;
    endcase
  end

  assign cur_byte = pend_q ? (rd_oor_q ? '0 : ram_byte) : shift_q;

  // next byte pointer, kept as row and byte within row as well
  assign ptr_inc = {1'b0, ptr_q} + (PtrW + 1)'(1);
  assign wrap    = ptr_inc >= {1'b0, cfg_i.frame_bytes};

  always_comb begin
    ptr_d        = ptr_q;
    row_d        = row_q;
    sub_d        = sub_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    latch_due_d  = latch_due_q;
    pend_d       = pend_q;
    rd_en        = 1'b0;
    out_period_d = out_period_q;
    out_high_d   = out_high_q;
    out_latch_d  = out_latch_q;
    if (tick) begin
      if (latch_due_q) begin
        out_period_d = nonzero_period(cfg_i.latch_period);
        out_high_d   = cfg_i.latch_high;
        out_latch_d  = 1'b1;
        latch_due_d  = 1'b0;
      end else begin
        out_period_d = nonzero_period(cfg_i.bit_period);
        out_high_d   = cur_byte[ByteW-1] ? cfg_i.one_high : cfg_i.zero_high;
        out_latch_d  = 1'b0;
        if (bit_cnt_q == 3'd0) begin
          bit_cnt_d = 3'd7;
          rd_en     = 1'b1;
          pend_d    = 1'b1;
          if (wrap) begin
            ptr_d       = '0;
            row_d       = '0;
            sub_d       = SUB_GREEN;
            latch_due_d = 1'b1;
          end else begin
            ptr_d = ptr_inc[PtrW-1:0];
            if (sub_q == SUB_BLUE) begin
              row_d = row_q + RowW'(1);
              sub_d = SUB_GREEN;
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end
        end else begin
          bit_cnt_d = bit_cnt_q - 3'd1;
          shift_d   = {cur_byte[ByteW-2:0], 1'b0};
          pend_d    = 1'b0;
        end
      end
    end
  end

  assign row_ext = {1'b0, row_d};

  wfs_ram #(
    .Width (PixW),
    .Depth (MaxLeds),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (row_ext[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // serializer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      row_q       <= '0;
      sub_q       <= SUB_GREEN;
      bit_cnt_q   <= 3'd7;
      shift_q     <= '0;
      latch_due_q <= 1'b0;
      pend_q      <= 1'b0;
      rd_sub_q    <= SUB_GREEN;
      rd_oor_q    <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      row_q       <= row_d;
      sub_q       <= sub_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      latch_due_q <= latch_due_d;
      pend_q      <= pend_d;
      if (rd_en) begin
        rd_sub_q <= sub_d;
        rd_oor_q <= !({2'b00, row_d} < LedLimit);
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_period_q <= out_period_d;
    out_high_q   <= out_high_d;
    out_latch_q  <= out_latch_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_period_o = out_period_q;
  assign out_high_o   = out_high_q;
  assign out_latch_o  = out_latch_q;

endmodule

// ===== design/ws2812_frame_serializer.sv =====
`timescale 1ns / 1ps
// a tick accepted at one edge has its pulse descriptor registered and shown at m_axis the next cycle
// throughput: one item per cycle, pixel writes and ticks alike, while no result is stalled
//   at m_axis; the store has its own write port and registered read port for the byte row prefetch
// reset: control and configuration registers clear at once, then a clearing pass
//   zeroes the store one pixel row a cycle with s_axis_tready low
module ws2812_frame_serializer #(
  parameter int unsigned MAX_LEDS = wfs_pkg::DefMaxLeds
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // led_index[11:0], red[19:12], green[27:20], blue[35:28], zero fill
  input  logic [39:0]                   s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // period_cycles[15:0], high_cycles[31:16]
  output logic [31:0]                   m_axis_tdata,
  // is_latch
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [wfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wfs_pkg::SlotW-1:0]     cfg_data_i
);
  import wfs_pkg::*;

  cfg_t             cfg;
  logic [SlotW-1:0] period, high;

  wfs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  wfs_core #(
    .MaxLeds (MAX_LEDS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser),
    .in_led_index_i (s_axis_tdata[11:0]),
    .in_red_i       (s_axis_tdata[19:12]),
    .in_green_i     (s_axis_tdata[27:20]),
    .in_blue_i      (s_axis_tdata[35:28]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_period_o   (period),
    .out_high_o     (high),
    .out_latch_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {high, period};

endmodule

// ===== design/wfs_checker.sv =====
`timescale 1ns / 1ps

module wfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [31:0]                   m_axis_tdata,
  input logic                          m_axis_tuser
);
  import wfs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // every tick transaction gives a result in the next cycle
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK |=> m_axis_tvalid)
    else $error("tick without result");

  // a pixel write gives no result
  a_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_PIXEL
      && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
    else $error("pixel write gave a result");

  // reported slot length is never zero
  a_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0)
    else $error("zero slot period");

endmodule

bind ws2812_frame_serializer wfs_checker u_wfs_checker (.*);

// ===== tb/tb_ws2812_frame_serializer.sv =====
`timescale 1ns / 1ps

module tb_ws2812_frame_serializer;
  import wfs_pkg::*;

  localparam int unsigned LEDS          = DefMaxLeds;
  localparam int unsigned STORE_BYTES   = 3 * LEDS;
  localparam int unsigned STUCK_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_NONE_HI = 3'd7;

  typedef enum logic [1:0] {PH_DATA, PH_LATCH_DUE, PH_LATCH_SENT} frame_phase_e;

  typedef struct packed {
    logic             op;
    logic [PtrW-1:0]  led;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } led_cmd_t;

  typedef struct packed {
    logic [SlotW-1:0] period;
    logic [SlotW-1:0] high;
    logic             latch;
  } pulse_slot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // led_index, red, green, blue, zero fill
  logic [39:0]         s_axis_tdata  = '0;
  // opcode
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // period_cycles, high_cycles
  logic [31:0]         m_axis_tdata;
  // is_latch
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [SlotW-1:0]    cfg_data_i    = '0;

  // serializer state mirrored by the predictor
  logic [ByteW-1:0] px_store [STORE_BYTES];
  logic [PtrW-1:0]  tx_ptr      = '0;
  logic [2:0]       bits_left   = 3'd7;
  logic [ByteW-1:0] shift_reg   = '0;
  frame_phase_e     frame_phase = PH_DATA;
  cfg_t             regs_copy;

  led_cmd_t    waiting_cmds [$];
  pulse_slot_t pending_slots [$];
  led_cmd_t    cur_cmd;
  logic        cmd_loaded = 1'b0;
  pulse_slot_t want;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold_req  = 1'b0;
  int unsigned sink_hold_left = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned mismatches     = 0;

  ws2812_frame_serializer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // expected pulse slot for one accepted command, if any
  task automatic step_serializer(input led_cmd_t c);
    logic [PtrW:0]   nxt;
    logic [PtrW-1:0] base;
    pulse_slot_t     s;
    if (c.op == OP_PIXEL) begin
      // store order is green, red, blue
      if (c.led < LEDS) begin
        base = PtrW'(3 * c.led);
        px_store[base]            = c.green;
        px_store[base + PtrW'(1)] = c.red;
        px_store[base + PtrW'(2)] = c.blue;
      end
    end else if (frame_phase == PH_LATCH_DUE) begin
      s.period = (regs_copy.latch_period == '0) ? SlotW'(1) : regs_copy.latch_period;
      s.high   = regs_copy.latch_high;
      s.latch  = 1'b1;
      pending_slots.push_back(s);
      frame_phase = PH_LATCH_SENT;
    end else begin
      frame_phase = PH_DATA;
      s.period = (regs_copy.bit_period == '0) ? SlotW'(1) : regs_copy.bit_period;
      s.high   = shift_reg[7] ? regs_copy.one_high : regs_copy.zero_high;
      s.latch  = 1'b0;
      pending_slots.push_back(s);
      if (bits_left == 3'd0) begin
        // last bit of the byte: prefetch the next one, wrap after the frame
        nxt       = {1'b0, tx_ptr} + (PtrW + 1)'(1);
        bits_left = 3'd7;
        if (nxt >= {1'b0, regs_copy.frame_bytes}) begin
          nxt         = '0;
          frame_phase = PH_LATCH_DUE;
        end
        tx_ptr    = nxt[PtrW-1:0];
        shift_reg = (tx_ptr < STORE_BYTES) ? px_store[tx_ptr] : '0;
      end else begin
        bits_left = bits_left - 3'd1;
        shift_reg = shift_reg << 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SlotW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_FRAME_BYTES: regs_copy.frame_bytes  = val[PtrW-1:0];
      REG_BIT_PERIOD:  regs_copy.bit_period   = val;
      REG_ONE_HIGH:    regs_copy.one_high     = val;
      REG_ZERO_HIGH:   regs_copy.zero_high    = val;
      REG_LATCH_PER:   regs_copy.latch_period = val;
      REG_LATCH_HIGH:  regs_copy.latch_high   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input logic [SlotW-1:0] fb, bp, oh, zh, lp, lh);
    write_reg(REG_FRAME_BYTES, fb);
    write_reg(REG_BIT_PERIOD, bp);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_LATCH_PER, lp);
    write_reg(REG_LATCH_HIGH, lh);
  endtask

  // wait until every command went in and every pulse slot came out
  task automatic wait_idle();
    while (waiting_cmds.size() != 0 || cmd_loaded || pending_slots.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic led_cmd_t tick_cmd();
    led_cmd_t c;
    c.op    = OP_TICK;
    c.led   = PtrW'($urandom);
    c.red   = ByteW'($urandom);
    c.green = ByteW'($urandom);
    c.blue  = ByteW'($urandom);
    return c;
  endfunction

  function automatic led_cmd_t pixel_cmd(input logic [PtrW-1:0] led,
                                         input logic [ByteW-1:0] g, r, b);
    led_cmd_t c;
    c.op    = OP_PIXEL;
    c.led   = led;
    c.green = g;
    c.red   = r;
    c.blue  = b;
    return c;
  endfunction

  // mostly ticks, most writes aimed at the pixels inside the current frame, some near the store end or anywhere
  function automatic led_cmd_t rand_cmd();
    led_cmd_t    c;
    int unsigned span;
    c = tick_cmd();
    if ($urandom_range(99) < 38) begin
      c.op = OP_PIXEL;
      span = (regs_copy.frame_bytes + 2) / 3;
      if (span > LEDS - 1) begin
        span = LEDS - 1;
      end
      case ($urandom_range(9))
        8: c.led = PtrW'($urandom_range(LEDS + 6, LEDS - 4));
        9: ;
        default: c.led = PtrW'($urandom_range(span));
      endcase
    end
    return c;
  endfunction

  // short frames so latch slots come often, junk in the unused upper bits
  function automatic logic [SlotW-1:0] rand_frame_len();
    logic [SlotW-1:0] v;
    v = SlotW'($urandom);
    case ($urandom_range(5))
      0: v[PtrW-1:0] = '0;
      1: v[PtrW-1:0] = 12'd1;
      default: v[PtrW-1:0] = PtrW'($urandom_range(9, 2));
    endcase
    return v;
  endfunction

  function automatic logic [SlotW-1:0] rand_slot();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return SlotW'($urandom_range(40, 1));
      default: return SlotW'($urandom);
    endcase
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_serializer(cur_cmd);
        cmd_loaded = 1'b0;
      end
      if (!cmd_loaded && waiting_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_cmd      = waiting_cmds.pop_front();
        cmd_loaded   = 1'b1;
        s_axis_tdata <= {4'h0, cur_cmd.blue, cur_cmd.green, cur_cmd.red, cur_cmd.led};
        s_axis_tuser <= cur_cmd.op;
      end
      s_axis_tvalid <= cmd_loaded;
    end
  end

  // long receiver hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold_left <= 0;
    end else if (sink_hold_req) begin
      sink_hold_left <= HOLD_CYCLES;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end
  end

  // pulse slot monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_slots.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected pulse slot: period %0d high %0d latch %0b",
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
          end
          mismatches++;
        end else begin
          want = pending_slots.pop_front();
          if (m_axis_tdata[15:0] !== want.period || m_axis_tdata[31:16] !== want.high ||
              m_axis_tuser !== want.latch) begin
            if (mismatches < 10) begin
              $display("pulse slot mismatch: expected period %0d high %0d latch %0b, %s",
                       want.period, want.high, want.latch, "got:");
              $display("  period %0d high %0d latch %0b",
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
            end
            mismatches++;
          end
        end
      end
      m_axis_tready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog on transactions at either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("ws2812_frame_serializer verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      px_store[i] = '0;
    end
    regs_copy = '{frame_bytes: RST_FRAME_BYTES, bit_period: RST_BIT_PERIOD,
                  one_high: RST_ONE_HIGH, zero_high: RST_ZERO_HIGH,
                  latch_period: RST_LATCH_PER, latch_high: RST_LATCH_HIGH};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: store edges, writes past the limit, prefetched byte rewritten
    waiting_cmds.push_back(pixel_cmd(12'd0, 8'h81, 8'hFF, 8'h00));
    waiting_cmds.push_back(pixel_cmd(12'd1023, 8'hFF, 8'hFF, 8'hFF));
    waiting_cmds.push_back(pixel_cmd(12'd1024, 8'h5A, 8'h5A, 8'h5A));
    waiting_cmds.push_back(pixel_cmd(12'd4095, 8'h0F, 8'hF0, 8'h0F));
    repeat (10) waiting_cmds.push_back(tick_cmd());
    waiting_cmds.push_back(pixel_cmd(12'd0, 8'h00, 8'h00, 8'h00));
    repeat (7) waiting_cmds.push_back(tick_cmd());
    wait_idle();

    // longest frame setting, zero periods, zero high width for a 0 bit, full one-bit and latch high widths
    load_regs({4'hF, 12'hFFF}, '0, '1, '0, '0, '1);
    write_reg(REG_NONE_LO, 16'hFFFF);
    write_reg(REG_NONE_HI, 16'h0000);
    waiting_cmds.push_back(pixel_cmd(12'd1022, 8'hC3, 8'h3C, 8'h96));
    repeat (40) waiting_cmds.push_back(tick_cmd());
    wait_idle();

    // random traffic under each idling pattern
    for (int mode = 0; mode < 4; mode++) begin
      for (int k = 0; k < 2; k++) begin
        case (mode)
          0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
          default: begin src_idle_pct = 12; sink_stall_pct = 12; end
        endcase
        load_regs(rand_frame_len(), rand_slot(), rand_slot(), rand_slot(), rand_slot(),
                  rand_slot());
        repeat (55) waiting_cmds.push_back(rand_cmd());
        wait_idle();
      end
    end

    // receiver holds off while the sender keeps offering, block backs up
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    load_regs(rand_frame_len(), rand_slot(), rand_slot(), rand_slot(), rand_slot(),
              rand_slot());
    sink_hold_req <= 1'b1;
    @(posedge clk_i);
    sink_hold_req <= 1'b0;
    repeat (50) waiting_cmds.push_back(rand_cmd());
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ws2812_frame_serializer verification clean");
    end else begin
      $display("ws2812_frame_serializer verification failed");
    end
    $finish;
  end

endmodule
